FILE: rtl/core/eoc_pkg.sv
package eoc_pkg;

	localparam int PROB_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 32;
	localparam int WARMUP_BITS    = 16;
	localparam int CFG_IDX_BITS   = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SIDE_UPPER   = 3'd0,
		CFG_WARMUP_CYC   = 3'd1,
		CFG_WARMUP_COUNT = 3'd2,
		CFG_REF_K        = 3'd3,
		CFG_THRESHOLD_H  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic                   side_upper;
		logic                   warmup_cyclical;
		logic [WARMUP_BITS-1:0] warmup_count;
	} mode_t;

	typedef struct packed {
		logic alarm;
		logic run_discarded;
		logic in_warmup;
	} flags_t;

endpackage

FILE: rtl/core/eocusum_steady_state_monitor_core.sv
// Risk-adjusted expected-minus-observed CUSUM monitor.
// Input channel (in_valid/in_ready): one beat per observation, carrying
// expected_prob (unsigned fraction) and outcome. Output channel
// (out_valid/out_ready): exactly one result beat per input beat, in order,
// with the statistic, run length and alarm/discard/warm-up flags.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
// cfg_index/cfg_data only while no observation is in flight.
// Path: each input beat is held in the input register, then passes the
// combinational CUSUM update into the result register.
// Throughput: one observation per cycle while out_ready is high; the
// statistic and run counter close their loop via add, clamp and compare.
// Reset: statistic, run counter and restart flag clear; registers return
// to lower side, conditional warm-up, no warm-up, k = 0, h = 2.0.
// Stall: while out_valid is held by a low out_ready, one more beat can be
// taken into the input register; then in_ready drops until the result
// is taken. No beats are lost or repeated.
module eocusum_steady_state_monitor_core #(
	parameter int PROB_BITS  = eoc_pkg::PROB_BITS_DEF,
	parameter int COUNT_BITS = eoc_pkg::COUNT_BITS_DEF,
	parameter int CFG_BITS   = ((PROB_BITS + 4) > eoc_pkg::WARMUP_BITS) ?
	                           (PROB_BITS + 4) : eoc_pkg::WARMUP_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [PROB_BITS-1:0]             expected_prob,
	input  logic                             outcome,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [PROB_BITS+5:0]      statistic,
	output logic [COUNT_BITS-1:0]            run_length,
	output logic                             alarm,
	output logic                             run_discarded,
	output logic                             in_warmup,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [eoc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]              cfg_data
);
	import eoc_pkg::*;

	mode_t                 mode;
	logic [PROB_BITS-1:0]  ref_k;
	logic [PROB_BITS+3:0]  thr_h;

	logic                  valid_s1;
	logic [PROB_BITS-1:0]  prob_s1;
	logic                  outcome_s1;
	logic                  advance;

	logic [PROB_BITS+5:0]  stat_d;
	logic [COUNT_BITS-1:0] rl_d;
	flags_t                flags_d;

	logic                  valid_s2;
	logic [PROB_BITS+5:0]  stat_s2;
	logic [COUNT_BITS-1:0] rl_s2;
	flags_t                flags_s2;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	eoc_cfg_regs #(
		.PROB_BITS (PROB_BITS),
		.CFG_BITS  (CFG_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.ref_k     (ref_k),
		.thr_h     (thr_h)
	);

	eoc_stat_unit #(
		.PROB_BITS  (PROB_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_stat (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.prob       (prob_s1),
		.outcome    (outcome_s1),
		.mode       (mode),
		.ref_k      (ref_k),
		.thr_h      (thr_h),
		.statistic  (stat_d),
		.run_length (rl_d),
		.flags      (flags_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prob_s1    <= expected_prob;
			outcome_s1 <= outcome;
		end
		if (advance) begin
			stat_s2  <= stat_d;
			rl_s2    <= rl_d;
			flags_s2 <= flags_d;
		end
	end

	assign out_valid     = valid_s2;
	assign statistic     = $signed(stat_s2);
	assign run_length    = rl_s2;
	assign alarm         = flags_s2.alarm;
	assign run_discarded = flags_s2.run_discarded;
	assign in_warmup     = flags_s2.in_warmup;

endmodule

FILE: rtl/core/eoc_cfg_regs.sv
module eoc_cfg_regs #(
	parameter int PROB_BITS = eoc_pkg::PROB_BITS_DEF,
	parameter int CFG_BITS  = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [eoc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]               cfg_data,
	output eoc_pkg::mode_t                    mode,
	output logic [PROB_BITS-1:0]              ref_k,
	output logic [PROB_BITS+3:0]              thr_h
);
	import eoc_pkg::*;

	localparam logic [PROB_BITS+3:0] H_RESET = (PROB_BITS+4)'(2 * (2 ** PROB_BITS));

	mode_t                mode_q;
	logic [PROB_BITS-1:0] ref_k_q;
	logic [PROB_BITS+3:0] thr_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			ref_k_q <= '0;
			thr_h_q <= H_RESET;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SIDE_UPPER:   mode_q.side_upper      <= cfg_data[0];
				CFG_WARMUP_CYC:   mode_q.warmup_cyclical <= cfg_data[0];
				CFG_WARMUP_COUNT: mode_q.warmup_count    <= cfg_data[WARMUP_BITS-1:0];
				CFG_REF_K:        ref_k_q                <= cfg_data[PROB_BITS-1:0];
				CFG_THRESHOLD_H:  thr_h_q                <= cfg_data[PROB_BITS+3:0];
				default: ;
			endcase
		end
	end

	assign mode  = mode_q;
	assign ref_k = ref_k_q;
	assign thr_h = thr_h_q;

endmodule

FILE: rtl/core/eoc_stat_unit.sv
module eoc_stat_unit #(
	parameter int PROB_BITS  = eoc_pkg::PROB_BITS_DEF,
	parameter int COUNT_BITS = eoc_pkg::COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic [PROB_BITS-1:0]     prob,
	input  logic                     outcome,
	input  eoc_pkg::mode_t           mode,
	input  logic [PROB_BITS-1:0]     ref_k,
	input  logic [PROB_BITS+3:0]     thr_h,
	output logic [PROB_BITS+5:0]     statistic,
	output logic [COUNT_BITS-1:0]    run_length,
	output eoc_pkg::flags_t          flags
);
	import eoc_pkg::*;

	localparam int SW = PROB_BITS + 7;
	localparam logic signed [SW-1:0] ONE   = SW'(2 ** PROB_BITS);
	localparam logic signed [SW-1:0] LIMIT = SW'(17 * (2 ** PROB_BITS) - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic signed [PROB_BITS+5:0] cusum_q;
	logic [COUNT_BITS-1:0]       obs_q;
	logic                        restart_q;

	logic signed [SW-1:0] base, z, kterm, sum, s, s_fin, h_ext;
	logic [COUNT_BITS-1:0] cnt_base, cnt, wc_ext;
	logic crossed, warm, restart_d;

	always_comb begin
		base     = restart_q ? '0 : SW'(cusum_q);
		cnt_base = restart_q ? '0 : obs_q;
		cnt      = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
		wc_ext   = COUNT_BITS'(mode.warmup_count);

		z     = $signed({{(SW-PROB_BITS){1'b0}}, prob}) - (outcome ? ONE : '0);
		kterm = $signed({{(SW-PROB_BITS){1'b0}}, ref_k});
		h_ext = $signed({{(SW-PROB_BITS-4){1'b0}}, thr_h});
		sum   = mode.side_upper ? base + z - kterm : base + z + kterm;

		if (mode.side_upper) begin
			s       = (sum < 0) ? '0 : ((sum > LIMIT) ? LIMIT : sum);
			crossed = s > h_ext;
		end else begin
			s       = (sum > 0) ? '0 : ((sum < -LIMIT) ? -LIMIT : sum);
			crossed = -s > h_ext;
		end

		warm      = cnt <= wc_ext;
		s_fin     = (crossed && warm && mode.warmup_cyclical) ? '0 : s;
		restart_d = crossed && (!warm || !mode.warmup_cyclical);

		statistic           = s_fin[PROB_BITS+5:0];
		run_length          = warm ? '0 : cnt - wc_ext;
		flags.alarm         = crossed && !warm;
		flags.run_discarded = crossed && warm && !mode.warmup_cyclical;
		flags.in_warmup     = warm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cusum_q   <= '0;
			obs_q     <= '0;
			restart_q <= 1'b0;
		end else if (advance) begin
			cusum_q   <= s_fin[PROB_BITS+5:0];
			obs_q     <= cnt;
			restart_q <= restart_d;
		end
	end

endmodule
